// ===== src/affine_tilemap_span_texel_fetch_defines.svh =====
// ----------------------------------------------------------------------------
// affine tile map span texel fetch: assertion macros
// shared property forms for the checker, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef AFFINE_TILEMAP_SPAN_TEXEL_FETCH_DEFINES_SVH
`define AFFINE_TILEMAP_SPAN_TEXEL_FETCH_DEFINES_SVH

// same-cycle implication
`define ATSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atsf: same-cycle check failed");

// next-cycle implication
`define ATSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atsf: next-cycle check failed");

`endif

// ===== src/atsf_pkg.sv =====
// ----------------------------------------------------------------------------
// atsf_pkg
// types, constants and codes shared by the span texel fetch pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atsf_pkg;

  localparam int MAP_ENTRIES_DEF = 4096;
  localparam int MAX_SPAN        = 64;
  localparam int FRAC_BITS       = 16;

  localparam logic [2:0] MAP_LOG2_MAX = 3'd6;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SPAN  = 1'b1;

  // mark bit positions
  localparam int MARK_SWAP   = 0;
  localparam int MARK_FLIP_V = 1;
  localparam int MARK_FLIP_U = 2;

  // register indexes
  localparam logic [2:0] REG_MAP_W   = 3'd0;
  localparam logic [2:0] REG_MAP_H   = 3'd1;
  localparam logic [2:0] REG_EDGE    = 3'd2;
  localparam logic [2:0] REG_DEFAULT = 3'd3;
  localparam logic [2:0] REG_EMPTY   = 3'd4;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_DEFAULT = 2'd1,
    EDGE_WRAP    = 2'd2,
    EDGE_CLAMP   = 2'd3
  } atsf_edge_t;

  typedef struct packed {
    logic [2:0]  map_width_log2;
    logic [2:0]  map_height_log2;
    atsf_edge_t  edge_mode;
    logic [11:0] default_entry;
    logic [15:0] blank_tile;
  } atsf_cfg_t;

  typedef struct packed {
    logic               func;
    logic [11:0]        entry_index;
    logic [15:0]        tile_value;
    logic [2:0]         transform_bits;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic [6:0]         pixel_count;
    logic [23:0]        dest_start;
    logic [1:0]         mip_level;
  } atsf_in_t;

  typedef struct packed {
    logic        draw;
    logic [6:0]  texel_u;
    logic [6:0]  texel_v;
    logic [23:0] dest_offset;
    logic        last;
  } atsf_out_t;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic        is_write;
    logic        last;
    logic [23:0] dest;
    logic [1:0]  mip;
    logic [2:0]  u;
    logic [2:0]  v;
  } atsf_tag_t;

  // map entry write payload
  typedef struct packed {
    logic [15:0] tile;
    logic [2:0]  mark;
  } atsf_wr_t;

  typedef struct packed {
    logic               valid;
    atsf_tag_t          tag;
    logic signed [12:0] tx;
    logic signed [12:0] ty;
    logic [11:0]        wr_idx;
    atsf_wr_t           wr;
  } atsf_s1_t;

  typedef struct packed {
    logic        valid;
    atsf_tag_t   tag;
    logic        hit;
    logic [11:0] idx;
    atsf_wr_t    wr;
  } atsf_lkp_t;

  typedef struct packed {
    logic        valid;
    atsf_tag_t   tag;
    logic        hit;
    logic [15:0] tile;
    logic [2:0]  mark;
  } atsf_rd_t;

endpackage

`default_nettype wire

// ===== src/atsf_walker.sv =====
// ----------------------------------------------------------------------------
// atsf_walker
// takes items, finds the tile, steps the span one pixel a cycle unless stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atsf_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  output logic                in_stall,
  input  atsf_pkg::atsf_in_t  in_data,
  output atsf_pkg::atsf_s1_t  s1
);

  logic               busy_r, busy_nxt;
  logic [31:0]        coord_x_r, coord_x_nxt;
  logic [31:0]        coord_y_r, coord_y_nxt;
  logic [31:0]        step_x_r, step_x_nxt;
  logic [31:0]        step_y_r, step_y_nxt;
  logic [6:0]         left_r, left_nxt;
  logic [23:0]        dest_r, dest_nxt;
  logic [1:0]         mip_r, mip_nxt;
  atsf_pkg::atsf_s1_t s1_r, s1_nxt;

  logic               acc;
  logic [6:0]         cnt_sat;
  logic signed [31:0] int_x, int_y;
  logic [15:0]        px, py;

  assign in_stall = busy_r || !adv;
  assign acc      = in_valid && !busy_r && adv;
  assign cnt_sat  = (in_data.pixel_count > 7'(atsf_pkg::MAX_SPAN)) ?
                    7'(atsf_pkg::MAX_SPAN) : in_data.pixel_count;

  // integer pixel position, sign kept through the shift
  assign int_x = $signed(coord_x_r) >>> atsf_pkg::FRAC_BITS;
  assign int_y = $signed(coord_y_r) >>> atsf_pkg::FRAC_BITS;
  assign px    = int_x[15:0];
  assign py    = int_y[15:0];

  always_comb begin
    busy_nxt    = busy_r;
    coord_x_nxt = coord_x_r;
    coord_y_nxt = coord_y_r;
    step_x_nxt  = step_x_r;
    step_y_nxt  = step_y_r;
    left_nxt    = left_r;
    dest_nxt    = dest_r;
    mip_nxt     = mip_r;

    s1_nxt              = '0;
    s1_nxt.valid        = busy_r;
    s1_nxt.tag.is_write = 1'b0;
    s1_nxt.tag.last     = (left_r == 7'd1);
    s1_nxt.tag.dest     = dest_r;
    s1_nxt.tag.mip      = mip_r;
    s1_nxt.tag.u        = px[2:0];
    s1_nxt.tag.v        = py[2:0];
    s1_nxt.tx           = $signed(px[15:3]);
    s1_nxt.ty           = $signed(py[15:3]);

    if (busy_r) begin
      coord_x_nxt = coord_x_r + step_x_r;
      coord_y_nxt = coord_y_r + step_y_r;
      left_nxt    = left_r - 7'd1;
      dest_nxt    = dest_r + 24'd1;
      busy_nxt    = (left_r != 7'd1);
    end

    if (acc) begin
      if (in_data.func == atsf_pkg::FUNC_WRITE) begin
        // write goes straight down the pipe as one slot
        s1_nxt              = '0;
        s1_nxt.valid        = 1'b1;
        s1_nxt.tag.is_write = 1'b1;
        s1_nxt.tag.last     = 1'b1;
        s1_nxt.wr_idx       = in_data.entry_index;
        s1_nxt.wr.tile      = in_data.tile_value;
        s1_nxt.wr.mark      = in_data.transform_bits;
      end else begin
        coord_x_nxt = in_data.start_x;
        coord_y_nxt = in_data.start_y;
        step_x_nxt  = in_data.step_x;
        step_y_nxt  = in_data.step_y;
        left_nxt    = cnt_sat;
        dest_nxt    = in_data.dest_start;
        mip_nxt     = in_data.mip_level;
        busy_nxt    = (cnt_sat != 7'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      s1_r.valid   <= 1'b0;
    end else if (adv) begin
      busy_r       <= busy_nxt;
      coord_x_r    <= coord_x_nxt;
      coord_y_r    <= coord_y_nxt;
      step_x_r     <= step_x_nxt;
      step_y_r     <= step_y_nxt;
      left_r       <= left_nxt;
      dest_r       <= dest_nxt;
      mip_r        <= mip_nxt;
      s1_r         <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

`default_nettype wire

// ===== src/atsf_locate.sv =====
// ----------------------------------------------------------------------------
// atsf_locate
// edge handling and map index, then wrap of the index into the store depth
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atsf_locate #(
  parameter int MAP_ENTRIES = atsf_pkg::MAP_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  atsf_pkg::atsf_cfg_t cfg,
  input  atsf_pkg::atsf_s1_t  s1,
  output atsf_pkg::atsf_lkp_t s3
);

  // store depth seen by a 12-bit index; a deeper store needs no wrap
  localparam int unsigned WRAP_N     = (MAP_ENTRIES < 4096) ? MAP_ENTRIES : 4096;
  localparam int unsigned WRAP_RECIP = (32'd1 << 24) / WRAP_N;

  atsf_pkg::atsf_lkp_t s2_r, s2_nxt;
  atsf_pkg::atsf_lkp_t s3_r, s3_nxt;

  logic [2:0]  wl, hl;
  logic [6:0]  w, h;
  logic [5:0]  wmask, hmask;
  logic        out_x, out_y, outside;
  logic [5:0]  cx, cy;
  logic [11:0] map_idx;

  // index modulo the store depth: reciprocal estimate, then one correction
  function automatic logic [11:0] wrap_index(input logic [11:0] val);
    logic [36:0] prod;
    logic [24:0] back;
    logic [12:0] rem;
    prod = 37'(val) * 37'(WRAP_RECIP);
    back = 25'(prod[35:24]) * 25'(WRAP_N);
    rem  = 13'(val) - back[12:0];
    if (rem >= 13'(WRAP_N)) rem = rem - 13'(WRAP_N);
    return rem[11:0];
  endfunction

  always_comb begin
    wl    = (cfg.map_width_log2 > atsf_pkg::MAP_LOG2_MAX) ?
            atsf_pkg::MAP_LOG2_MAX : cfg.map_width_log2;
    hl    = (cfg.map_height_log2 > atsf_pkg::MAP_LOG2_MAX) ?
            atsf_pkg::MAP_LOG2_MAX : cfg.map_height_log2;
    w     = 7'd1 << wl;
    h     = 7'd1 << hl;
    wmask = 6'(w - 7'd1);
    hmask = 6'(h - 7'd1);

    out_x   = s1.tx[12] || (s1.tx[11:0] >= 12'(w));
    out_y   = s1.ty[12] || (s1.ty[11:0] >= 12'(h));
    outside = out_x || out_y;

    cx = s1.tx[5:0] & wmask;
    cy = s1.ty[5:0] & hmask;
    if (outside && cfg.edge_mode == atsf_pkg::EDGE_CLAMP) begin
      if (out_x) cx = s1.tx[12] ? 6'd0 : wmask;
      if (out_y) cy = s1.ty[12] ? 6'd0 : hmask;
    end
    map_idx = 12'(cx) + (12'(cy) << wl);

    s2_nxt       = '0;
    s2_nxt.valid = s1.valid;
    s2_nxt.tag   = s1.tag;
    s2_nxt.wr    = s1.wr;
    if (s1.tag.is_write) begin
      s2_nxt.hit = 1'b1;
      s2_nxt.idx = s1.wr_idx;
    end else if (outside && cfg.edge_mode == atsf_pkg::EDGE_DEFAULT) begin
      // outside tile reads the default entry index directly
      s2_nxt.hit = 1'b1;
      s2_nxt.idx = cfg.default_entry;
    end else begin
      s2_nxt.hit = !(outside && cfg.edge_mode == atsf_pkg::EDGE_NONE);
      s2_nxt.idx = map_idx;
    end

    s3_nxt     = s2_r;
    s3_nxt.idx = wrap_index(s2_r.idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

`default_nettype wire

// ===== src/atsf_map_mem.sv =====
// ----------------------------------------------------------------------------
// atsf_map_mem
// tile map store: while the pipe is not stalled, one write or one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atsf_map_mem #(
  parameter int MAP_ENTRIES = atsf_pkg::MAP_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  atsf_pkg::atsf_lkp_t s3,
  output atsf_pkg::atsf_rd_t  s4
);

  localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  logic [18:0]        map_mem_r [MAP_ENTRIES];
  logic [18:0]        rd_data_r;
  atsf_pkg::atsf_tag_t tag_r;
  logic               valid_r;
  logic               hit_r;
  logic [AW-1:0]      addr;

  assign addr = AW'(s3.idx);

  always_ff @(posedge clk) begin
    if (adv && s3.valid && s3.tag.is_write) begin
      map_mem_r[addr] <= {s3.wr.tile, s3.wr.mark};
    end
    if (adv) begin
      rd_data_r <= map_mem_r[addr];
      tag_r     <= s3.tag;
      hit_r     <= s3.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s3.valid;
    end
  end

  assign s4.valid = valid_r;
  assign s4.tag   = tag_r;
  assign s4.hit   = hit_r;
  assign s4.tile  = rd_data_r[18:3];
  assign s4.mark  = rd_data_r[2:0];

endmodule

`default_nettype wire

// ===== src/atsf_texel.sv =====
// ----------------------------------------------------------------------------
// atsf_texel
// mark transform, sprite sheet offset, mip shift, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atsf_texel (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  atsf_pkg::atsf_cfg_t cfg,
  input  atsf_pkg::atsf_rd_t  s4,
  output logic                out_valid,
  output atsf_pkg::atsf_out_t out_data
);

  logic                out_valid_r;
  atsf_pkg::atsf_out_t out_data_r, out_data_nxt;
  logic                draw;
  logic [2:0]          u, v, t;
  logic [6:0]          u7, v7;

  always_comb begin
    draw = !s4.tag.is_write && s4.hit && (s4.tile != cfg.blank_tile);
    u    = s4.tag.u;
    v    = s4.tag.v;
    if (s4.mark[atsf_pkg::MARK_FLIP_V]) v = ~v;
    if (s4.mark[atsf_pkg::MARK_FLIP_U]) u = ~u;
    if (s4.mark[atsf_pkg::MARK_SWAP]) begin
      t = u;
      u = v;
      v = t;
    end else begin
      t = u;
    end
    u7 = {s4.tile[3:0], u} >> s4.tag.mip;
    v7 = {s4.tile[7:4], v} >> s4.tag.mip;

    out_data_nxt.draw        = draw;
    out_data_nxt.texel_u     = draw ? u7 : 7'd0;
    out_data_nxt.texel_v     = draw ? v7 : 7'd0;
    out_data_nxt.dest_offset = s4.tag.dest;
    out_data_nxt.last        = s4.tag.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4.valid;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/affine_tilemap_span_texel_fetch.sv =====
// ----------------------------------------------------------------------------
// affine_tilemap_span_texel_fetch
// affine tiled background: tile map store and per-pixel texel fetch
// ----------------------------------------------------------------------------
// A write item (func 0) stores a tile id and 3-bit mark in the tile map and
// answers with one result (all zero, last set). A span item (func 1) walks a
// signed 16.16 coordinate for pixel_count pixels (capped at 64, zero gives no
// result) and gives one result per pixel: the draw flag, the sprite sheet
// texel shifted by the mip level and the destination offset, with last on
// the final pixel. The coordinate walker issues one pixel per cycle while
// out_stall does not hold the pipe; in_stall stays high while a span's pixels
// issue, so no new item is taken until the span is done, and a write item
// or a span of zero pixels does not hold the input. Walker, tile locate,
// index wrap, map read (one port, registered) and texel shaping are one
// register stage each, texel shaping being the output register. out_stall
// freezes every stage at once, so nothing is dropped or repeated. The map
// store has no reset; reading an entry never written gives an unspecified
// texel. Registers sit on the APB port at byte addresses 0 (map width
// log2), 4 (map height log2), 8 (edge mode), 12 (default entry) and 16
// (empty tile) and are to be written by the user only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module affine_tilemap_span_texel_fetch #(
  parameter int MAP_ENTRIES = atsf_pkg::MAP_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,

  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  atsf_pkg::atsf_in_t  in_data,

  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output atsf_pkg::atsf_out_t out_data,

  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  atsf_pkg::atsf_cfg_t cfg_r;
  atsf_pkg::atsf_s1_t  s1;
  atsf_pkg::atsf_lkp_t s3;
  atsf_pkg::atsf_rd_t  s4;
  logic                adv;
  logic                cfg_we;
  logic [2:0]          reg_sel;

  // whole pipe moves unless a result is waiting on a stalled sink
  assign adv = !(out_valid && out_stall);

  // register port: zero wait states
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        atsf_pkg::REG_MAP_W:   cfg_r.map_width_log2  <= pwdata[2:0];
        atsf_pkg::REG_MAP_H:   cfg_r.map_height_log2 <= pwdata[2:0];
        atsf_pkg::REG_EDGE:    cfg_r.edge_mode       <= atsf_pkg::atsf_edge_t'(pwdata[1:0]);
        atsf_pkg::REG_DEFAULT: cfg_r.default_entry   <= pwdata[11:0];
        atsf_pkg::REG_EMPTY:   cfg_r.blank_tile      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      atsf_pkg::REG_MAP_W:   prdata = 32'(cfg_r.map_width_log2);
      atsf_pkg::REG_MAP_H:   prdata = 32'(cfg_r.map_height_log2);
      atsf_pkg::REG_EDGE:    prdata = 32'(cfg_r.edge_mode);
      atsf_pkg::REG_DEFAULT: prdata = 32'(cfg_r.default_entry);
      atsf_pkg::REG_EMPTY:   prdata = 32'(cfg_r.blank_tile);
      default:               prdata = 32'd0;
    endcase
  end

  // coordinate walker, first stage
  atsf_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1       (s1)
  );

  // edge modes and index wrap, two stages
  atsf_locate #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_locate (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg_r),
    .s1    (s1),
    .s3    (s3)
  );

  // tile map store, writes and reads in pipe order
  atsf_map_mem #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_map_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s3    (s3),
    .s4    (s4)
  );

  // texel shaping and output register
  atsf_texel u_texel (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg_r),
    .s4        (s4),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/atsf_checker.sv =====
// ----------------------------------------------------------------------------
// atsf_checker
// port-level checks on the span texel fetch, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "affine_tilemap_span_texel_fetch_defines.svh"

module atsf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input atsf_pkg::atsf_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input atsf_pkg::atsf_out_t out_data
);

  // held result keeps its payload
  `ATSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a stalled sink freezes the input side too
  `ATSF_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall)

  // skipped pixels carry no texel
  `ATSF_ASSERT_NOW(a_skip_zero, out_valid && !out_data.draw,
                   out_data.texel_u == 7'd0 && out_data.texel_v == 7'd0)

  // a span with pixels keeps the walker busy the next cycle
  `ATSF_ASSERT_NEXT(a_span_busy,
                    in_valid && !in_stall && in_data.func == atsf_pkg::FUNC_SPAN &&
                    in_data.pixel_count != 7'd0, in_stall)

endmodule

bind affine_tilemap_span_texel_fetch atsf_checker u_atsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
